### hw/rtl/sorted_double_ended_priority_queue_core_macros.svh
// assertion macros for the sorted double-ended priority queue core
// bodies refer to clk_i and rst_ni of the module that uses them
`ifndef SORTED_DOUBLE_ENDED_PRIORITY_QUEUE_CORE_MACROS_SVH
`define SORTED_DOUBLE_ENDED_PRIORITY_QUEUE_CORE_MACROS_SVH

`ifndef SYNTHESIS
// expression holds at every clock edge out of reset
`define SDPQ_ASSERT(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);
// consequent holds in the cycle after the antecedent
`define SDPQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SDPQ_ASSERT(label, expr, msg)
`define SDPQ_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

### hw/rtl/sdpq_pkg.sv
// shared types and codes for the sorted double-ended priority queue
// no dependencies
`default_nettype none

package sdpq_pkg;

  localparam int unsigned DataW = 32;

  localparam logic [1:0] CMD_INSERT  = 2'd0;
  localparam logic [1:0] CMD_DEL_MIN = 2'd1;
  localparam logic [1:0] CMD_DEL_MAX = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // broadcast from the top level to every cell
  typedef struct packed {
    logic                    insert;
    logic                    shift_down;
    logic signed [DataW-1:0] key;
  } cell_ctrl_t;

endpackage

`default_nettype wire

### hw/rtl/sdpq_cell.sv
// one storage cell of the sorted chain
// depends on sdpq_pkg
`default_nettype none

module sdpq_cell import sdpq_pkg::*; (
  input  wire logic                    clk_i,
  input  wire cell_ctrl_t              ctrl_i,
  input  wire logic                    occ_i,
  input  wire logic                    left_occ_i,
  input  wire logic                    left_ge_i,
  input  wire logic signed [DataW-1:0] left_entry_i,
  input  wire logic signed [DataW-1:0] right_entry_i,
  output logic                         ge_o,
  output logic signed [DataW-1:0]      entry_o
);

  logic signed [DataW-1:0] entry_q, entry_d;
  logic                    first_free;

  assign ge_o       = occ_i && ($signed(entry_q) >= $signed(ctrl_i.key));
  assign first_free = !occ_i && left_occ_i;
  assign entry_o    = entry_q;

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.insert) begin
      // left neighbor moves up when the new key lands at or before it
      if (left_ge_i) begin
        entry_d = left_entry_i;
      end else if (ge_o || first_free) begin
        entry_d = ctrl_i.key;
      end
    end else if (ctrl_i.shift_down) begin
      entry_d = right_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

`default_nettype wire

### hw/rtl/sorted_double_ended_priority_queue_core.sv
// top level of the sorted double-ended priority queue: a chain of sdpq_cell
// depends on sdpq_pkg, sdpq_cell and the core macros header
//
// Holds up to CAPACITY signed 32-bit values in ascending order, one value
// per cell. A command (command_i, value_i) is taken at a rising edge where
// start_i is high and busy_o is low. busy_o stays low: every cell compares
// its value against the broadcast key and shifts in the same cycle, so a
// new command may follow every cycle.
// Insert places the value in sorted order; delete-min shifts the whole
// chain down by one cell; delete-max drops the last held value.
// Each command gives one result in the cycle after acceptance: done_o is high
// for exactly one cycle with status_o, removed_value_o and entry_count_o.
// The receiver cannot stall; results must be taken on the strobe.
// Throughput 1 command per cycle, set by the compare and shift in every cell.
// Reset empties the store (count to zero); cell contents are not cleared
// and are never read before being written.
`default_nettype none
`include "sorted_double_ended_priority_queue_core_macros.svh"

module sorted_double_ended_priority_queue_core import sdpq_pkg::*; #(
  parameter int unsigned CAPACITY = 16
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start_i,
  input  wire logic [1:0]              command_i,
  input  wire logic signed [DataW-1:0] value_i,
  output logic                         busy_o,
  output logic                         done_o,
  output logic [1:0]                   status_o,
  output logic signed [DataW-1:0]      removed_value_o,
  output logic [4:0]                   entry_count_o
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  logic [CntW-1:0]         cnt_q, cnt_d;
  logic                    done_q;
  logic [1:0]              status_q, status_d;
  logic signed [DataW-1:0] removed_q, removed_d;

  logic [CAPACITY-1:0]     occ;
  logic [CAPACITY-1:0]     ge;
  logic [CAPACITY-1:0]     last_hit;
  logic signed [DataW-1:0] entry [CAPACITY];
  logic [CntW+4:0]         cnt_ext;

  logic       accept, is_full, is_empty;
  logic       do_ins, do_del_min, do_del_max;
  cell_ctrl_t ctrl;
  logic signed [DataW-1:0] max_val;

  assign busy_o   = 1'b0;
  assign accept   = start_i && !busy_o;
  assign is_full  = (cnt_q == CntW'(CAPACITY));
  assign is_empty = (cnt_q == '0);

  assign do_ins     = accept && (command_i == CMD_INSERT) && !is_full;
  assign do_del_min = accept && (command_i == CMD_DEL_MIN) && !is_empty;
  assign do_del_max = accept && (command_i == CMD_DEL_MAX) && !is_empty;

  assign ctrl.insert     = do_ins;
  assign ctrl.shift_down = do_del_min;
  assign ctrl.key        = value_i;

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      assign occ[gi] = (cnt_q > CntW'(gi));
      if (gi == CAPACITY - 1) begin : g_last
        assign last_hit[gi] = occ[gi];
      end else begin : g_mid
        assign last_hit[gi] = occ[gi] && !occ[gi+1];
      end

      if (gi == 0) begin : g_head
        sdpq_cell u_cell (
          .clk_i        (clk_i),
          .ctrl_i       (ctrl),
          .occ_i        (occ[gi]),
          .left_occ_i   (1'b1),
          .left_ge_i    (1'b0),
          .left_entry_i (ctrl.key),
          .right_entry_i(entry[(CAPACITY > 1) ? 1 : 0]),
          .ge_o         (ge[gi]),
          .entry_o      (entry[gi])
        );
      end else if (gi == CAPACITY - 1) begin : g_tail
        sdpq_cell u_cell (
          .clk_i        (clk_i),
          .ctrl_i       (ctrl),
          .occ_i        (occ[gi]),
          .left_occ_i   (occ[gi-1]),
          .left_ge_i    (ge[gi-1]),
          .left_entry_i (entry[gi-1]),
          .right_entry_i(entry[gi]),
          .ge_o         (ge[gi]),
          .entry_o      (entry[gi])
        );
      end else begin : g_body
        sdpq_cell u_cell (
          .clk_i        (clk_i),
          .ctrl_i       (ctrl),
          .occ_i        (occ[gi]),
          .left_occ_i   (occ[gi-1]),
          .left_ge_i    (ge[gi-1]),
          .left_entry_i (entry[gi-1]),
          .right_entry_i(entry[gi+1]),
          .ge_o         (ge[gi]),
          .entry_o      (entry[gi])
        );
      end
    end
  endgenerate

  // and-or select of the last held value
  always_comb begin
    max_val = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      max_val = max_val | (entry[i] & {DataW{last_hit[i]}});
    end
  end

  always_comb begin
    cnt_d     = cnt_q;
    status_d  = ST_OK;
    removed_d = '0;
    if (accept) begin
      case (command_i)
        CMD_INSERT: begin
          if (is_full) begin
            status_d = ST_FULL;
          end else begin
            cnt_d = cnt_q + CntW'(1);
          end
        end
        CMD_DEL_MIN, CMD_DEL_MAX: begin
          if (is_empty) begin
            status_d = ST_EMPTY;
          end else begin
            cnt_d     = cnt_q - CntW'(1);
            removed_d = do_del_min ? entry[0] : max_val;
          end
        end
        default: begin
          status_d = ST_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q  <= status_d;
    removed_q <= removed_d;
  end

  assign cnt_ext         = {5'd0, cnt_q};
  assign done_o          = done_q;
  assign status_o        = status_q;
  assign removed_value_o = removed_q;
  assign entry_count_o   = cnt_ext[4:0];

  `SDPQ_ASSERT(a_cnt_bound, cnt_q <= CntW'(CAPACITY), "count above capacity")
  `SDPQ_ASSERT_NEXT(a_one_result, accept, done_o, "accepted item without result")
  `SDPQ_ASSERT_NEXT(a_empty_flag, accept && is_empty && (command_i == CMD_DEL_MIN ||
    command_i == CMD_DEL_MAX), status_o == ST_EMPTY && cnt_q == '0, "empty delete mishandled")
  `SDPQ_ASSERT_NEXT(a_full_keep, accept && is_full && command_i == CMD_INSERT,
    status_o == ST_FULL && cnt_q == CntW'(CAPACITY), "full insert changed count")
  `SDPQ_ASSERT(a_min_le_next, !(occ[0] && (CAPACITY > 1) && occ[(CAPACITY > 1) ? 1 : 0]) ||
    (entry[0] <= entry[(CAPACITY > 1) ? 1 : 0]), "head cells out of order")

endmodule

`default_nettype wire

### tb/sdpq_checker.sv
// checker for the sorted double-ended priority queue core: tracks accepted commands,
// keeps its own sorted copy of the store and compares every result on done
// depends on sdpq_pkg
module sdpq_checker import sdpq_pkg::*; #(
  parameter int unsigned CAPACITY = 16
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start_i,
  input  wire logic                    busy_i,
  input  wire logic [1:0]              command_i,
  input  wire logic signed [DataW-1:0] value_i,
  input  wire logic                    done_i,
  input  wire logic [1:0]              status_i,
  input  wire logic signed [DataW-1:0] removed_value_i,
  input  wire logic [4:0]              entry_count_i,
  output int unsigned                  fail_count_o,
  output int unsigned                  pending_o
);

  typedef struct packed {
    logic [1:0]              status;
    logic signed [DataW-1:0] removed;
    logic [4:0]              count;
  } queue_result_t;

  // ascending copy of what the store should hold
  logic signed [DataW-1:0] held_values[$];
  queue_result_t           expected_results[$];
  queue_result_t           want;

  function automatic queue_result_t apply_command(input logic [1:0] cmd,
                                                  input logic signed [DataW-1:0] val);
    queue_result_t res;
    int unsigned   pos;
    res.status  = ST_OK;
    res.removed = '0;
    case (cmd)
      CMD_INSERT: begin
        if (held_values.size() >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          pos = 0;
          while (pos < held_values.size() && held_values[pos] < val) pos++;
          held_values.insert(pos, val);
        end
      end
      CMD_DEL_MIN, CMD_DEL_MAX: begin
        if (held_values.size() == 0) begin
          res.status = ST_EMPTY;
        end else if (cmd == CMD_DEL_MIN) begin
          res.removed = held_values.pop_front();
        end else begin
          res.removed = held_values.pop_back();
        end
      end
      default: ;  // unused code leaves the store alone
    endcase
    res.count = 5'(held_values.size());
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_values.delete();
      expected_results.delete();
      pending_o = 0;
    end else begin
      if (start_i && !busy_i) expected_results.push_back(apply_command(command_i, value_i));
      if (done_i) begin
        if (expected_results.size() == 0) begin
          $error("result with no item outstanding");
          fail_count_o++;
        end else begin
          want = expected_results.pop_front();
          if (status_i !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status_i);
            fail_count_o++;
          end
          if (removed_value_i !== want.removed) begin
            $error("removed_value: expected %0d, got %0d", want.removed, removed_value_i);
            fail_count_o++;
          end
          if (entry_count_i !== want.count) begin
            $error("entry_count: expected %0d, got %0d", want.count, entry_count_i);
            fail_count_o++;
          end
        end
      end
      pending_o = expected_results.size();
    end
  end

endmodule

### tb/tb.sv
// testbench top for the sorted double-ended priority queue core: directed and
// random commands with random gaps; depends on sdpq_pkg, the core and sdpq_checker
module tb;
  import sdpq_pkg::*;

  localparam int unsigned Capacity   = 16;
  localparam int unsigned NumRandom  = 600;
  localparam int unsigned CycleLimit = 200000;
  localparam logic [1:0]  CmdUnused  = 2'd3;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    start_i = 1'b0;
  logic [1:0]              command_i = CMD_INSERT;
  logic signed [DataW-1:0] value_i = '0;
  logic                    busy_o;
  logic                    done_o;
  logic [1:0]              status_o;
  logic signed [DataW-1:0] removed_value_o;
  logic [4:0]              entry_count_o;
  int unsigned             fail_count;
  int unsigned             pending;
  int unsigned             cycle_count = 0;

  always #5 clk_i = ~clk_i;

  sorted_double_ended_priority_queue_core #(.CAPACITY(Capacity)) u_dut (
    .clk_i, .rst_ni, .start_i, .command_i, .value_i,
    .busy_o, .done_o, .status_o, .removed_value_o, .entry_count_o
  );

  sdpq_checker #(.CAPACITY(Capacity)) u_checker (
    .clk_i, .rst_ni, .start_i,
    .busy_i          (busy_o),
    .command_i, .value_i,
    .done_i          (done_o),
    .status_i        (status_o),
    .removed_value_i (removed_value_o),
    .entry_count_i   (entry_count_o),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("[sorted_double_ended_priority_queue_core] ERROR");
      $finish;
    end
  end

  // hold the item on the inputs until the core takes it
  task automatic issue(input logic [1:0] cmd, input logic signed [DataW-1:0] val);
    start_i   <= 1'b1;
    command_i <= cmd;
    value_i   <= val;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  // idle cycles after an item, with junk on the payload while start is low
  task automatic idle_for(input int unsigned cycles);
    repeat (cycles) begin
      start_i   <= 1'b0;
      command_i <= 2'($urandom);
      value_i   <= $urandom;
      @(posedge clk_i);
    end
  endtask

  function automatic logic signed [DataW-1:0] pick_value();
    int unsigned mode;
    mode = $urandom_range(0, 9);
    case (mode)
      0, 1, 2, 3, 4: return $urandom;
      5, 6, 7:       return $signed($urandom_range(0, 15)) - 8;  // many duplicates
      8: begin
        case ($urandom_range(0, 3))
          0:       return 32'sh7fffffff;
          1:       return 32'sh80000000;
          2:       return '0;
          default: return -1;
        endcase
      end
      default: begin
        if ($urandom_range(0, 1) == 0) return 32'sh7fffffff - $urandom_range(0, 3);
        return 32'sh80000000 + $urandom_range(0, 3);
      end
    endcase
  endfunction

  function automatic int unsigned pick_gap(input bit no_idle);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (no_idle || roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  initial begin
    logic [1:0]  cmd;
    int unsigned insert_pct;
    int unsigned roll;
    bit          no_idle;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty store, unused code, extremes, duplicates, then fill past full
    issue(CMD_DEL_MIN, 32'sd5);
    issue(CMD_DEL_MAX, -32'sd5);
    issue(CmdUnused, 32'sh7fffffff);
    issue(CMD_INSERT, 32'sh7fffffff);
    issue(CMD_INSERT, 32'sh80000000);
    issue(CMD_INSERT, '0);
    issue(CMD_INSERT, -1);
    issue(CMD_INSERT, 32'sd1);
    issue(CMD_INSERT, '0);
    issue(CMD_DEL_MIN, '0);
    issue(CMD_DEL_MAX, '0);
    issue(CmdUnused, 32'sh80000000);
    for (int i = 0; i < 12; i++) begin
      issue(CMD_INSERT, pick_value());
      idle_for(i % 3);
    end
    issue(CMD_INSERT, 32'sd42);

    insert_pct = 50;
    no_idle    = 1'b0;
    for (int i = 0; i < NumRandom; i++) begin
      // phases that drift the fill level toward full, empty or stay balanced
      if (i % 40 == 0) begin
        case ($urandom_range(0, 3))
          0:       insert_pct = 80;
          1:       insert_pct = 20;
          2:       insert_pct = 50;
          default: insert_pct = $urandom_range(0, 100);
        endcase
        no_idle = ($urandom_range(0, 3) == 0);
      end
      roll = $urandom_range(0, 99);
      if (roll < 2) cmd = CmdUnused;
      else if ($urandom_range(0, 99) < insert_pct) cmd = CMD_INSERT;
      else if ($urandom_range(0, 1) == 0) cmd = CMD_DEL_MIN;
      else cmd = CMD_DEL_MAX;
      issue(cmd, pick_value());
      idle_for(pick_gap(no_idle));
    end
    start_i <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("[sorted_double_ended_priority_queue_core] OK");
    end else begin
      $display("[sorted_double_ended_priority_queue_core] ERROR");
    end
    $finish;
  end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/sdpq_pkg.sv
hw/rtl/sdpq_cell.sv
hw/rtl/sorted_double_ended_priority_queue_core.sv
tb/sdpq_checker.sv
tb/tb.sv
